>>> src/ptrs_pkg.sv
// Package: shared types, codes and constants of the task table scheduler.
package ptrs_pkg;

  localparam int SLOTS_DEF       = 32;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam int KIND_W    = 3;
  localparam int ID_W      = 8;
  localparam int STATUS_W  = 3;
  localparam int OUT_ID_W  = 6;
  localparam int STATE_W   = 2;
  localparam int OUT_CNT_W = 6;

  localparam logic [ID_W-1:0] VIRT_ID_LO = 8'd96;
  localparam logic [ID_W-1:0] VIRT_ID_HI = 8'd99;

  typedef enum logic [KIND_W-1:0] {
    KIND_CREATE,
    KIND_EXIT,
    KIND_KILL,
    KIND_BLOCK,
    KIND_UNBLOCK,
    KIND_SCHED,
    KIND_QUERY,
    KIND_REAP
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK,
    STATUS_PROTECTED,
    STATUS_INVALID,
    STATUS_NO_TASK,
    STATUS_FULL,
    STATUS_NO_CHANGE
  } status_e;

  typedef enum logic [STATE_W-1:0] {
    SLOT_READY,
    SLOT_RUNNING,
    SLOT_BLOCKED,
    SLOT_TERM
  } slot_state_e;

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_EXEC,
    SEQ_CREATE,
    SEQ_SCHED_A,
    SEQ_SCHED_B,
    SEQ_DONE
  } seq_state_e;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   target_id;
    logic              start_running;
    logic              stack_intact;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [OUT_ID_W-1:0]  task_id_out;
    logic                 switched;
    logic [STATE_W-1:0]   state_out;
    logic                 found;
    logic [OUT_CNT_W-1:0] occ_count;
  } rsp_t;

  typedef struct packed {
    kind_e           kind;
    logic [ID_W-1:0] target_id;
    logic [ID_W-1:0] slot;
    logic            id_zero;
    logic            id_prot;
    logic            id_over;
    logic            id_virt;
    logic            start_running;
    logic            stack_intact;
  } cmd_t;

endpackage

>>> src/ptrs_fifo.sv
// Small register queue used between the front, the back and the result port.
module ptrs_fifo #(
  parameter type T     = logic,
  parameter int  Depth = ptrs_pkg::QUEUE_DEPTH_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  T     wdata_i,
  output logic full_o,
  input  logic pop_i,
  output T     rdata_o,
  output logic empty_o
);
  import ptrs_pkg::*;

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  T                mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

>>> src/ptrs_front.sv
// Front end: accept requests, decode the kind and classify the target id.
module ptrs_front #(
  parameter int Slots = ptrs_pkg::SLOTS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  ptrs_pkg::req_t  req_i,
  output logic            full_o,
  output logic            cmd_push_o,
  output ptrs_pkg::cmd_t  cmd_o,
  input  logic            cmd_full_i
);
  import ptrs_pkg::*;

  logic hold_q, hold_d;
  cmd_t cmd_q, cmd_d;
  cmd_t cls;
  logic accept;

  always_comb begin
    cls.kind          = kind_e'(req_i.kind);
    cls.target_id     = req_i.target_id;
    cls.slot          = req_i.target_id - ID_W'(1);
    cls.id_zero       = (req_i.target_id == '0);
    cls.id_prot       = (req_i.target_id < ID_W'(2));
    cls.id_over       = (32'(req_i.target_id) > Slots);
    cls.id_virt       = (req_i.target_id >= VIRT_ID_LO) && (req_i.target_id <= VIRT_ID_HI);
    cls.start_running = req_i.start_running;
    cls.stack_intact  = req_i.stack_intact;
  end

  assign full_o     = hold_q && cmd_full_i;
  assign accept     = push_i && !full_o;
  assign cmd_push_o = hold_q && !cmd_full_i;
  assign cmd_o      = cmd_q;

  always_comb begin
    hold_d = hold_q;
    cmd_d  = cmd_q;
    if (accept) begin
      hold_d = 1'b1;
      cmd_d  = cls;
    end else if (cmd_push_o) begin
      hold_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= 1'b0;
    end else begin
      hold_q <= hold_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
  end

endmodule

>>> src/ptrs_back.sv
// Back end: task table, counters and the sequencer that carries out requests.
module ptrs_back #(
  parameter int Slots = ptrs_pkg::SLOTS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic            cfg_wdata_i,
  input  ptrs_pkg::cmd_t  cmd_i,
  input  logic            cmd_empty_i,
  output logic            cmd_pop_o,
  output ptrs_pkg::rsp_t  rsp_o,
  output logic            rsp_push_o,
  input  logic            rsp_full_i
);
  import ptrs_pkg::*;

  localparam int IdxW = $clog2(Slots);
  localparam int CntW = $clog2(Slots + 1);

  seq_state_e        seq_q, seq_d;
  cmd_t              cmd_q, cmd_d;
  logic              enable_q;
  logic [Slots-1:0]  valid_q, valid_d;
  slot_state_e       state_q [Slots];
  slot_state_e       state_d [Slots];
  logic [CntW-1:0]   current_q, current_d;
  logic [CntW-1:0]   before_q, before_d;
  logic [CntW-1:0]   cur_eff_q, cur_eff_d;
  logic [IdxW-1:0]   rr_q, rr_d;
  logic [CntW-1:0]   occ_q, occ_d;
  logic [CntW-1:0]   term_q, term_d;
  status_e           status_q, status_d;
  logic [CntW-1:0]   tid_q, tid_d;
  slot_state_e       st_q, st_d;
  logic              found_q, found_d;
  logic              intact_q, intact_d;
  logic              quiet_q, quiet_d;

  logic              wr_en, wr_valid, reap_en;
  logic [IdxW-1:0]   wr_idx;
  slot_state_e       wr_state;
  logic              old_v, old_t, new_t;

  logic [Slots-1:0]  running_v, term_v, cand_v, cand_hi_v;
  logic [IdxW:0]     run_ff, free_ff, hi_ff, all_ff;
  logic [IdxW-1:0]   tgt, cur_idx, cur_eff_idx, e_idx, pick;
  logic              e_ok, got;

  function automatic logic [IdxW:0] first_set(input logic [Slots-1:0] v);
    logic [IdxW:0] r;
    r = '0;
    for (int i = Slots - 1; i >= 0; i--) begin
      if (v[i]) begin
        r = {1'b1, IdxW'(i)};
      end
    end
    return r;
  endfunction

  assign tgt         = cmd_q.slot[IdxW-1:0];
  assign cur_idx     = IdxW'(current_q - CntW'(1));
  assign cur_eff_idx = IdxW'(cur_eff_q - CntW'(1));

  always_comb begin
    for (int i = 0; i < Slots; i++) begin
      running_v[i] = valid_q[i] && (state_q[i] == SLOT_RUNNING);
      term_v[i]    = valid_q[i] && (state_q[i] == SLOT_TERM);
      cand_v[i]    = valid_q[i] && (state_q[i] == SLOT_READY) && (CntW'(i + 1) != cur_eff_q);
      cand_hi_v[i] = cand_v[i] && (IdxW'(i) > rr_q);
    end
  end

  assign run_ff  = first_set(running_v);
  assign free_ff = first_set(~valid_q);
  assign hi_ff   = first_set(cand_hi_v);
  assign all_ff  = first_set(cand_v);
  assign got     = all_ff[IdxW];
  assign pick    = hi_ff[IdxW] ? hi_ff[IdxW-1:0] : all_ff[IdxW-1:0];

  always_comb begin
    if (current_q != '0) begin
      e_ok  = valid_q[cur_idx];
      e_idx = cur_idx;
    end else begin
      e_ok  = run_ff[IdxW];
      e_idx = run_ff[IdxW-1:0];
    end
  end

  always_comb begin
    seq_d     = seq_q;
    cmd_d     = cmd_q;
    current_d = current_q;
    before_d  = before_q;
    cur_eff_d = cur_eff_q;
    rr_d      = rr_q;
    status_d  = status_q;
    tid_d     = tid_q;
    st_d      = st_q;
    found_d   = found_q;
    intact_d  = intact_q;
    quiet_d   = quiet_q;
    wr_en     = 1'b0;
    wr_idx    = tgt;
    wr_valid  = 1'b0;
    wr_state  = SLOT_READY;
    reap_en   = 1'b0;
    cmd_pop_o  = 1'b0;
    rsp_push_o = 1'b0;

    case (seq_q)
      SEQ_IDLE: begin
        if (!cmd_empty_i && !rsp_full_i) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          before_d  = current_q;
          status_d  = STATUS_OK;
          tid_d     = '0;
          st_d      = SLOT_READY;
          found_d   = 1'b0;
          seq_d     = SEQ_EXEC;
        end
      end
      SEQ_EXEC: begin
        seq_d = SEQ_DONE;
        case (cmd_q.kind)
          KIND_CREATE: begin
            reap_en = 1'b1;
            seq_d   = SEQ_CREATE;
          end
          KIND_EXIT: begin
            if (!e_ok) begin
              status_d = STATUS_NO_TASK;
            end else if (e_idx == '0) begin
              status_d = STATUS_PROTECTED;
            end else begin
              wr_en     = 1'b1;
              wr_idx    = e_idx;
              wr_valid  = 1'b1;
              wr_state  = SLOT_TERM;
              current_d = '0;
              intact_d  = 1'b1;
              quiet_d   = 1'b1;
              seq_d     = SEQ_SCHED_A;
            end
          end
          KIND_KILL: begin
            if (cmd_q.id_prot) begin
              status_d = STATUS_PROTECTED;
            end else if (cmd_q.id_virt || cmd_q.id_over) begin
              status_d = STATUS_INVALID;
            end else if (!valid_q[tgt]) begin
              status_d = STATUS_NO_TASK;
            end else if (CntW'(cmd_q.target_id) == current_q) begin
              wr_en     = 1'b1;
              wr_valid  = 1'b1;
              wr_state  = SLOT_TERM;
              current_d = '0;
              intact_d  = 1'b1;
              quiet_d   = 1'b1;
              seq_d     = SEQ_SCHED_A;
            end else begin
              wr_en = 1'b1;
            end
          end
          KIND_BLOCK: begin
            if (cmd_q.id_prot) begin
              status_d = STATUS_PROTECTED;
            end else if (cmd_q.id_over) begin
              status_d = STATUS_INVALID;
            end else if (!valid_q[tgt]) begin
              status_d = STATUS_NO_TASK;
            end else if (state_q[tgt] != SLOT_READY) begin
              status_d = STATUS_NO_CHANGE;
            end else begin
              wr_en    = 1'b1;
              wr_valid = 1'b1;
              wr_state = SLOT_BLOCKED;
            end
          end
          KIND_UNBLOCK: begin
            if (cmd_q.id_zero || cmd_q.id_over) begin
              status_d = STATUS_INVALID;
            end else if (!valid_q[tgt]) begin
              status_d = STATUS_NO_TASK;
            end else if (state_q[tgt] != SLOT_BLOCKED) begin
              status_d = STATUS_NO_CHANGE;
            end else begin
              wr_en    = 1'b1;
              wr_valid = 1'b1;
              wr_state = SLOT_READY;
            end
          end
          KIND_SCHED: begin
            intact_d = cmd_q.stack_intact;
            quiet_d  = 1'b0;
            seq_d    = SEQ_SCHED_A;
          end
          KIND_QUERY: begin
            if (cmd_q.id_zero || cmd_q.id_over) begin
              status_d = STATUS_INVALID;
            end else if (!valid_q[tgt]) begin
              status_d = STATUS_NO_TASK;
            end else begin
              st_d    = state_q[tgt];
              found_d = 1'b1;
            end
          end
          KIND_REAP: begin
            reap_en = 1'b1;
          end
          default: begin
            seq_d = SEQ_DONE;
          end
        endcase
      end
      SEQ_CREATE: begin
        seq_d = SEQ_DONE;
        if (!free_ff[IdxW]) begin
          status_d = STATUS_FULL;
        end else begin
          wr_en    = 1'b1;
          wr_idx   = free_ff[IdxW-1:0];
          wr_valid = 1'b1;
          wr_state = cmd_q.start_running ? SLOT_RUNNING : SLOT_READY;
          tid_d    = CntW'(free_ff[IdxW-1:0]) + CntW'(1);
          if (cmd_q.start_running) begin
            current_d = CntW'(free_ff[IdxW-1:0]) + CntW'(1);
          end
        end
      end
      SEQ_SCHED_A: begin
        if ((occ_q == '0) || !enable_q) begin
          if (!quiet_q) begin
            status_d = STATUS_NO_CHANGE;
          end
          seq_d = SEQ_DONE;
        end else begin
          cur_eff_d = current_q;
          if (current_q != '0) begin
            wr_idx = cur_idx;
            if (!intact_q) begin
              wr_en     = 1'b1;
              current_d = '0;
              cur_eff_d = '0;
            end else if (running_v[cur_idx]) begin
              wr_en    = 1'b1;
              wr_valid = 1'b1;
              wr_state = SLOT_READY;
            end
          end
          seq_d = SEQ_SCHED_B;
        end
      end
      SEQ_SCHED_B: begin
        seq_d    = SEQ_DONE;
        wr_valid = 1'b1;
        wr_state = SLOT_RUNNING;
        if (got) begin
          wr_en     = 1'b1;
          wr_idx    = pick;
          current_d = CntW'(pick) + CntW'(1);
          rr_d      = pick;
        end else if (valid_q[0]) begin
          wr_en     = 1'b1;
          wr_idx    = '0;
          current_d = CntW'(1);
        end else if ((cur_eff_q != '0) && valid_q[cur_eff_idx]) begin
          wr_en  = 1'b1;
          wr_idx = cur_eff_idx;
        end
      end
      SEQ_DONE: begin
        rsp_push_o = 1'b1;
        seq_d      = SEQ_IDLE;
      end
      default: begin
        seq_d = SEQ_IDLE;
      end
    endcase
  end

  assign old_v = valid_q[wr_idx];
  assign old_t = old_v && (state_q[wr_idx] == SLOT_TERM);
  assign new_t = wr_valid && (wr_state == SLOT_TERM);

  always_comb begin
    valid_d = valid_q;
    state_d = state_q;
    occ_d   = occ_q;
    term_d  = term_q;
    if (reap_en) begin
      for (int i = 0; i < Slots; i++) begin
        if (term_v[i]) begin
          valid_d[i] = 1'b0;
          state_d[i] = SLOT_READY;
        end
      end
      occ_d  = occ_q - term_q;
      term_d = '0;
    end
    if (wr_en) begin
      valid_d[wr_idx] = wr_valid;
      state_d[wr_idx] = wr_state;
      if (wr_valid && !old_v) begin
        occ_d = occ_q + CntW'(1);
      end else if (!wr_valid && old_v) begin
        occ_d = occ_q - CntW'(1);
      end
      if (new_t && !old_t) begin
        term_d = term_q + CntW'(1);
      end else if (!new_t && old_t) begin
        term_d = term_q - CntW'(1);
      end
    end
  end

  always_comb begin
    rsp_o.status      = status_q;
    rsp_o.task_id_out = ((cmd_q.kind == KIND_EXIT) || (cmd_q.kind == KIND_KILL) ||
                         (cmd_q.kind == KIND_SCHED)) ? OUT_ID_W'(current_q) : OUT_ID_W'(tid_q);
    rsp_o.switched    = (current_q != '0) && (current_q != before_q);
    rsp_o.state_out   = st_q;
    rsp_o.found       = found_q;
    rsp_o.occ_count   = OUT_CNT_W'(occ_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q     <= SEQ_IDLE;
      enable_q  <= 1'b0;
      valid_q   <= '0;
      current_q <= '0;
      rr_q      <= '0;
      occ_q     <= '0;
      term_q    <= '0;
      for (int i = 0; i < Slots; i++) begin
        state_q[i] <= SLOT_READY;
      end
    end else begin
      seq_q     <= seq_d;
      valid_q   <= valid_d;
      state_q   <= state_d;
      current_q <= current_d;
      rr_q      <= rr_d;
      occ_q     <= occ_d;
      term_q    <= term_d;
      if (cfg_we_i) begin
        enable_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    before_q  <= before_d;
    cur_eff_q <= cur_eff_d;
    status_q  <= status_d;
    tid_q     <= tid_d;
    st_q      <= st_d;
    found_q   <= found_d;
    intact_q  <= intact_d;
    quiet_q   <= quiet_d;
  end

`ifndef ASSERT_OFF
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(occ_q) <= Slots)
    else $error("live count exceeds slot count");

  a_term_le_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    term_q <= occ_q)
    else $error("terminated count exceeds live count");

  a_cur_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (current_q != '0) |-> valid_q[cur_idx])
    else $error("current task names an empty slot");

  a_pop_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |=> (seq_q == SEQ_EXEC))
    else $error("request taken without execution");
`endif

endmodule

>>> src/process_table_round_robin_scheduler.sv
// Top level: round-robin task table scheduler with queue-style ports.
// Usage:
//   Requests enter on push_i/req_i and are taken at an edge where push_i is
//   high and full_o is low. Results leave in request order on rsp_o: one is
//   valid while empty_o is low and is taken at an edge where pop_i is high.
//   One result per request. cfg_we_i/cfg_wdata_i write the scheduler enable
//   at any edge where cfg_we_i is high; write it only while idle.
// Sequencer:
//   Query, block, unblock, reap, kill of another task and refused requests
//   pass through execute and done in the back-end sequencer; create reaps
//   in execute and then allocates, and schedule and exit or kill of the
//   current task demote or drop it, then run the round-robin search and
//   write-back, a pass skipped when the table is empty or disabled. The
//   sequencer takes the next request only after pushing the last result.
// Reset:
//   rst_ni clears the task table, counters, current task, pointer, enable
//   and both queues at once. When pop_i stays low the result queue fills,
//   the back end stops taking commands, and full_o rises once the command
//   queue and the front register are occupied; nothing is dropped.
module process_table_round_robin_scheduler #(
  parameter int Slots      = ptrs_pkg::SLOTS_DEF,
  parameter int QueueDepth = ptrs_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  ptrs_pkg::req_t  req_i,
  output logic            full_o,
  input  logic            pop_i,
  output ptrs_pkg::rsp_t  rsp_o,
  output logic            empty_o,
  input  logic            cfg_we_i,
  input  logic            cfg_wdata_i
);
  import ptrs_pkg::*;

  cmd_t front_cmd, back_cmd;
  rsp_t back_rsp;
  logic front_push, cmd_full, cmd_empty, cmd_pop;
  logic rsp_push, rsp_full;

  ptrs_front #(
    .Slots(Slots)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push_i),
    .req_i      (req_i),
    .full_o     (full_o),
    .cmd_push_o (front_push),
    .cmd_o      (front_cmd),
    .cmd_full_i (cmd_full)
  );

  ptrs_fifo #(
    .T     (ptrs_pkg::cmd_t),
    .Depth (QueueDepth)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_push),
    .wdata_i (front_cmd),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .rdata_o (back_cmd),
    .empty_o (cmd_empty)
  );

  ptrs_back #(
    .Slots(Slots)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (back_cmd),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .rsp_o       (back_rsp),
    .rsp_push_o  (rsp_push),
    .rsp_full_i  (rsp_full)
  );

  ptrs_fifo #(
    .T     (ptrs_pkg::rsp_t),
    .Depth (QueueDepth)
  ) u_rsp_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rsp_push),
    .wdata_i (back_rsp),
    .full_o  (rsp_full),
    .pop_i   (pop_i),
    .rdata_o (rsp_o),
    .empty_o (empty_o)
  );

endmodule
